// ===== hw/rtl/adam_parameter_update_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with arst_n as disable.
// ----------------------------------------------------------------------------
`ifndef ADAM_PARAMETER_UPDATE_ASSERT_SVH
`define ADAM_PARAMETER_UPDATE_ASSERT_SVH

// same-cycle implication
`define APU_AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define APU_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/apu_pkg.sv =====
// ----------------------------------------------------------------------------
// apu_pkg
// Types and constants shared by the Adam parameter update engine.
// ----------------------------------------------------------------------------
package apu_pkg;

	localparam int IDX_W = 10;

	typedef enum logic [1:0] {
		ACT_LOAD    = 2'd0,
		ACT_GRAD    = 2'd1,
		ACT_READ    = 2'd2,
		ACT_RESTART = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		CFG_LR  = 2'd0,
		CFG_B1  = 2'd1,
		CFG_B2  = 2'd2,
		CFG_EPS = 2'd3
	} cfg_idx_t;

	localparam logic [31:0] LR_RST  = 32'd4294967;
	localparam logic [15:0] B1_RST  = 16'd58982;
	localparam logic [15:0] B2_RST  = 16'd65470;
	localparam logic [31:0] EPS_RST = 32'd43;
	localparam logic [15:0] POW_RST = 16'hFFFF;
	localparam logic [33:0] DELTA_CAP = 34'h2_0000_0000;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LATCH,
		OP_CLEAR,
		OP_LOAD,
		OP_RESTART,
		OP_TAKE_RD,
		OP_MOMENT,
		OP_VMUL,
		OP_VSUM,
		OP_WB,
		OP_DIV_M,
		OP_DIV_V,
		OP_SQRT,
		OP_LR_LO,
		OP_LR_HI,
		OP_LR_SUM,
		OP_DIV_D,
		OP_DELTA,
		OP_UPDATE,
		OP_RESULT
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_FETCH,
		ST_PICK,
		ST_RCLEAR,
		ST_MOM,
		ST_VMUL,
		ST_VSUM,
		ST_WB,
		ST_DIVM,
		ST_WAITM,
		ST_DIVV,
		ST_WAITV,
		ST_SQRT,
		ST_WAITS,
		ST_LRLO,
		ST_LRHI,
		ST_LRSUM,
		ST_DIVD,
		ST_WAITD,
		ST_DELTA,
		ST_UPD,
		ST_DONE
	} state_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		act_t act;
		logic in_range;
		logic s_zero;
		logic div_busy;
		logic sqrt_busy;
		logic clr_last;
	} stat_t;

endpackage

// ===== hw/rtl/adam_parameter_update.sv =====
// ----------------------------------------------------------------------------
// adam_parameter_update
// Adam optimizer engine over a table of Q16.16 parameters with moments.
// ----------------------------------------------------------------------------
// One item is in flight at a time; the result register lets the next item be
// taken while a result waits. A gradient item runs three 64-step bit-serial
// divisions (bias correction of both moments and the final step quotient) and a
// 32-step square root in one shared divider and one root unit, plus sequencing
// and multiply/accumulate steps; a zero root denominator skips the last
// division. Restart and the pass after reset each sweep the moment-valid table,
// one entry a cycle, and take no items while they sweep.
module adam_parameter_update
	import apu_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // entry_index[9:0], operand_value[41:10], zero pad
	input  logic [1:0]  s_tuser,  // action[1:0]
	input  logic        s_tlast,  // end_of_step
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata   // result_index[9:0], parameter_value[41:10],
	                              // step_number[57:42], zero pad
);

	cmd_t  cmd;
	stat_t st;

	assign cfg_ready = 1'b1;

	apu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.st       (st)
	);

	apu_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.st        (st)
	);

endmodule

// ===== hw/rtl/apu_div.sv =====
// ----------------------------------------------------------------------------
// apu_div
// 128/64 restoring divider, one quotient bit per cycle, saturating to 64 bits.
// ----------------------------------------------------------------------------
module apu_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num_hi,
	input  logic [63:0] num_lo,
	input  logic [63:0] den,
	output logic        busy,
	output logic [63:0] quo
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] lo_q;
	logic [63:0] q_q;
	logic [63:0] den_q;
	logic [63:0] rem_sh;
	logic        fits;

	// remainder stays below den < 2^63, so the shift never loses a bit
	assign rem_sh = {rem_q[62:0], lo_q[63]};
	assign fits   = rem_sh >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !((den == '0) || den[63] || (num_hi >= den));
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd63)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num_hi;
			lo_q  <= num_lo;
			den_q <= den;
			if ((den == '0) || den[63] || (num_hi >= den))
				q_q <= '1;
			else
				q_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - den_q) : rem_sh;
			lo_q  <= {lo_q[62:0], 1'b0};
			q_q   <= {q_q[62:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = q_q;

endmodule

// ===== hw/rtl/apu_sqrt.sv =====
// ----------------------------------------------------------------------------
// apu_sqrt
// 64-bit integer square root, digit-by-digit, one result bit per cycle.
// ----------------------------------------------------------------------------
module apu_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] x_in,
	output logic        busy,
	output logic [31:0] root
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [63:0] x_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x_in;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (x_q >= trial) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = res_q[31:0];

endmodule

// ===== hw/rtl/apu_dpath.sv =====
// ----------------------------------------------------------------------------
// apu_dpath
// Datapath: entry tables, step bookkeeping, moment arithmetic, divider, root.
// ----------------------------------------------------------------------------
module apu_dpath
	import apu_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [47:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        s_tlast,
	output logic [63:0] m_tdata,
	input  cmd_t        cmd,
	output stat_t       st
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [16:0] DEPTH_L = 17'(TABLE_DEPTH);
	localparam logic [AW-1:0] CLR_END = AW'(TABLE_DEPTH - 1);

	// configuration
	logic [31:0] lr_q;
	logic [15:0] b1_q;
	logic [15:0] b2_q;
	logic [31:0] eps_q;

	// step bookkeeping
	logic [15:0] step_q;
	logic [15:0] p1_q;
	logic [15:0] p2_q;
	logic        open_q;
	logic [AW-1:0] clr_q;

	// item
	act_t              act_q;
	logic [IDX_W-1:0]  idx_q;
	logic [AW-1:0]     addr_q;
	logic              inside_q;
	logic signed [31:0] g_q;
	logic              last_q;

	// tables
	logic [31:0] par_mem [TABLE_DEPTH];
	logic [47:0] m_mem   [TABLE_DEPTH];
	logic [63:0] v_mem   [TABLE_DEPTH];
	logic        vld_mem [TABLE_DEPTH];
	logic [31:0] par_rd_q;
	logic [47:0] m_rd_q;
	logic [63:0] v_rd_q;
	logic        vld_rd_q;

	// arithmetic
	logic signed [64:0] pm1_q;
	logic signed [49:0] pm2_q;
	logic [63:0]        gsq_q;
	logic [47:0]        mnew_q;
	logic [79:0]        pv_q;
	logic [80:0]        pg_q;
	logic [63:0]        vnew_q;
	logic [63:0]        mhat_q;
	logic [48:0]        s_q;
	logic [63:0]        pa_q;
	logic [63:0]        pb_q;
	logic [95:0]        prod_q;
	logic [33:0]        delta_q;
	logic [31:0]        res_val_q;

	// result register
	logic [IDX_W-1:0] out_idx_q;
	logic [31:0]      out_val_q;
	logic [15:0]      out_step_q;

	logic [16:0]        idx_ext;
	logic signed [47:0] m_old;
	logic [63:0]        v_old;
	logic signed [16:0] b1_s;
	logic signed [17:0] c1_s;
	logic [16:0]        c2;
	logic [31:0]        g_abs;
	logic signed [66:0] m_sum;
	logic [81:0]        v_sum;
	logic [47:0]        m_abs;
	logic [16:0]        den_p1;
	logic [16:0]        den_p2;
	logic [31:0]        pw1;
	logic [31:0]        pw2;
	logic               div_start;
	logic [63:0]        div_hi;
	logic [63:0]        div_lo;
	logic [63:0]        div_den;
	logic               div_busy;
	logic [63:0]        div_quo;
	logic               sqrt_busy;
	logic [31:0]        sqrt_root;
	logic signed [35:0] p_ext;
	logic signed [35:0] p_new;
	logic [31:0]        p_sat;
	logic               vld_we;
	logic [AW-1:0]      vld_wa;

	assign idx_ext = {{(17 - IDX_W){1'b0}}, s_tdata[IDX_W-1:0]};

	assign m_old  = vld_rd_q ? $signed(m_rd_q) : '0;
	assign v_old  = vld_rd_q ? v_rd_q : '0;
	assign b1_s   = $signed({1'b0, b1_q});
	assign c1_s   = $signed({1'b0, 17'h1_0000 - {1'b0, b1_q}});
	assign c2     = 17'h1_0000 - {1'b0, b2_q};
	assign g_abs  = g_q[31] ? (~g_q + 32'd1) : g_q;
	assign m_sum  = $signed({{2{pm1_q[64]}}, pm1_q}) + $signed({pm2_q[49], pm2_q, 16'b0});
	assign v_sum  = {2'b0, pv_q} + {1'b0, pg_q};
	assign m_abs  = mnew_q[47] ? (~mnew_q + 48'd1) : mnew_q;
	assign den_p1 = 17'h1_0000 - {1'b0, p1_q};
	assign den_p2 = 17'h1_0000 - {1'b0, p2_q};
	assign pw1    = p1_q * b1_q;
	assign pw2    = p2_q * b2_q;

	assign div_start = (cmd.op == OP_DIV_M) || (cmd.op == OP_DIV_V) || (cmd.op == OP_DIV_D);

	always_comb begin
		case (cmd.op)
			OP_DIV_M: begin
				div_hi  = '0;
				div_lo  = {m_abs, 16'b0};
				div_den = {47'b0, den_p1};
			end
			OP_DIV_V: begin
				div_hi  = {48'b0, vnew_q[63:48]};
				div_lo  = {vnew_q[47:0], 16'b0};
				div_den = {47'b0, den_p2};
			end
			default: begin
				div_hi  = {48'b0, prod_q[95:80]};
				div_lo  = prod_q[79:16];
				div_den = {15'b0, s_q};
			end
		endcase
	end

	apu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_hi (div_hi),
		.num_lo (div_lo),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	apu_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_SQRT),
		.x_in   (div_quo),
		.busy   (sqrt_busy),
		.root   (sqrt_root)
	);

	// parameter update with saturation to signed 32 bits
	assign p_ext = $signed({{4{par_rd_q[31]}}, par_rd_q});
	assign p_new = mnew_q[47] ? (p_ext + $signed({2'b0, delta_q}))
		: (p_ext - $signed({2'b0, delta_q}));
	always_comb begin
		if (!p_new[35] && (p_new[34:31] != 4'b0000))
			p_sat = 32'h7FFF_FFFF;
		else if (p_new[35] && (p_new[34:31] != 4'b1111))
			p_sat = 32'h8000_0000;
		else
			p_sat = p_new[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q   <= LR_RST;
			b1_q   <= B1_RST;
			b2_q   <= B2_RST;
			eps_q  <= EPS_RST;
			step_q <= '0;
			p1_q   <= POW_RST;
			p2_q   <= POW_RST;
			open_q <= 1'b0;
			clr_q  <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_LR:  lr_q  <= cfg_data;
					CFG_B1:  b1_q  <= cfg_data[15:0];
					CFG_B2:  b2_q  <= cfg_data[15:0];
					CFG_EPS: eps_q <= cfg_data;
					default: ;
				endcase
			end
			case (cmd.op)
				OP_CLEAR: clr_q <= (clr_q == CLR_END) ? '0 : clr_q + AW'(1);
				OP_RESTART: begin
					step_q <= '0;
					p1_q   <= POW_RST;
					p2_q   <= POW_RST;
					open_q <= 1'b0;
				end
				OP_MOMENT: begin
					if (!open_q) begin
						if (step_q != 16'hFFFF)
							step_q <= step_q + 16'd1;
						p1_q   <= pw1[31:16];
						p2_q   <= pw2[31:16];
						open_q <= 1'b1;
					end
				end
				OP_UPDATE: begin
					if (last_q)
						open_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LATCH: begin
				act_q    <= act_t'(s_tuser);
				idx_q    <= s_tdata[IDX_W-1:0];
				addr_q   <= idx_ext[AW-1:0];
				inside_q <= idx_ext < DEPTH_L;
				g_q      <= $signed(s_tdata[IDX_W+31:IDX_W]);
				last_q   <= s_tlast;
			end
			OP_LOAD:    res_val_q <= g_q;
			OP_TAKE_RD: res_val_q <= par_rd_q;
			OP_MOMENT: begin
				pm1_q <= b1_s * m_old;
				pm2_q <= c1_s * g_q;
				gsq_q <= g_abs * g_abs;
			end
			OP_VMUL: begin
				mnew_q <= m_sum[63:16];
				pv_q   <= v_old * b2_q;
				pg_q   <= gsq_q * c2;
			end
			OP_VSUM:  vnew_q <= v_sum[79:16];
			OP_DIV_V: mhat_q <= div_quo;
			OP_LR_LO: begin
				s_q  <= {1'b0, sqrt_root, 16'b0} + {17'b0, eps_q};
				pa_q <= lr_q * mhat_q[31:0];
			end
			OP_LR_HI:  pb_q   <= lr_q * mhat_q[63:32];
			OP_LR_SUM: prod_q <= {32'b0, pa_q} + {pb_q, 32'b0};
			OP_DELTA: begin
				// a zero denominator takes the cap unless the corrected first moment is zero
				if (s_q == '0)
					delta_q <= (mhat_q != '0) ? DELTA_CAP : '0;
				else if (div_quo > {30'b0, DELTA_CAP})
					delta_q <= DELTA_CAP;
				else
					delta_q <= div_quo[33:0];
			end
			OP_UPDATE: res_val_q <= p_sat;
			OP_RESULT: begin
				out_idx_q  <= idx_q;
				out_val_q  <= inside_q ? res_val_q : '0;
				out_step_q <= step_q;
			end
			default: ;
		endcase
	end

	// tables: one write port each, read data registered
	assign vld_we = (cmd.op == OP_CLEAR) || (cmd.op == OP_WB);
	assign vld_wa = (cmd.op == OP_CLEAR) ? clr_q : addr_q;

	always_ff @(posedge clk) begin
		if (inside_q && ((cmd.op == OP_LOAD) || (cmd.op == OP_UPDATE)))
			par_mem[addr_q] <= (cmd.op == OP_LOAD) ? g_q : p_sat;
		if (cmd.op == OP_WB) begin
			m_mem[addr_q] <= mnew_q;
			v_mem[addr_q] <= vnew_q;
		end
		if (vld_we)
			vld_mem[vld_wa] <= (cmd.op == OP_WB);
		par_rd_q <= par_mem[addr_q];
		m_rd_q   <= m_mem[addr_q];
		v_rd_q   <= v_mem[addr_q];
		vld_rd_q <= vld_mem[addr_q];
	end

	assign st.act       = act_q;
	assign st.in_range  = inside_q;
	assign st.s_zero    = (s_q == '0);
	assign st.div_busy  = div_busy;
	assign st.sqrt_busy = sqrt_busy;
	assign st.clr_last  = (clr_q == CLR_END);

	assign m_tdata = {6'b0, out_step_q, out_val_q, out_idx_q};

endmodule

// ===== hw/rtl/apu_ctrl.sv =====
// ----------------------------------------------------------------------------
// apu_ctrl
// Sequencer: input/output handshakes and the per-item command sequence.
// ----------------------------------------------------------------------------
module apu_ctrl
	import apu_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	output logic  m_tvalid,
	input  logic  m_tready,
	output cmd_t  cmd,
	input  stat_t st
);

	`include "adam_parameter_update_assert.svh"

	state_t state_q;
	state_t state_d;
	logic   out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == OP_RESULT)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			ST_INIT: begin
				cmd.op = OP_CLEAR;
				if (st.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = OP_LATCH;
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				unique case (st.act)
					ACT_LOAD: begin
						cmd.op  = OP_LOAD;
						state_d = ST_DONE;
					end
					ACT_READ: state_d = ST_PICK;
					ACT_RESTART: begin
						cmd.op  = OP_RESTART;
						state_d = ST_RCLEAR;
					end
					ACT_GRAD: state_d = st.in_range ? ST_MOM : ST_PICK;
					default:  state_d = ST_PICK;
				endcase
			end
			ST_RCLEAR: begin
				cmd.op = OP_CLEAR;
				if (st.clr_last)
					state_d = ST_PICK;
			end
			ST_PICK: begin
				cmd.op  = OP_TAKE_RD;
				state_d = ST_DONE;
			end
			ST_MOM: begin
				cmd.op  = OP_MOMENT;
				state_d = ST_VMUL;
			end
			ST_VMUL: begin
				cmd.op  = OP_VMUL;
				state_d = ST_VSUM;
			end
			ST_VSUM: begin
				cmd.op  = OP_VSUM;
				state_d = ST_WB;
			end
			ST_WB: begin
				cmd.op  = OP_WB;
				state_d = ST_DIVM;
			end
			ST_DIVM: begin
				cmd.op  = OP_DIV_M;
				state_d = ST_WAITM;
			end
			ST_WAITM: begin
				if (!st.div_busy)
					state_d = ST_DIVV;
			end
			ST_DIVV: begin
				cmd.op  = OP_DIV_V;
				state_d = ST_WAITV;
			end
			ST_WAITV: begin
				if (!st.div_busy)
					state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.op  = OP_SQRT;
				state_d = ST_WAITS;
			end
			ST_WAITS: begin
				if (!st.sqrt_busy)
					state_d = ST_LRLO;
			end
			ST_LRLO: begin
				cmd.op  = OP_LR_LO;
				state_d = ST_LRHI;
			end
			ST_LRHI: begin
				cmd.op  = OP_LR_HI;
				state_d = ST_LRSUM;
			end
			ST_LRSUM: begin
				cmd.op  = OP_LR_SUM;
				state_d = ST_DIVD;
			end
			ST_DIVD: begin
				// zero denominator: no division, delta picked directly
				if (st.s_zero) begin
					state_d = ST_DELTA;
				end else begin
					cmd.op  = OP_DIV_D;
					state_d = ST_WAITD;
				end
			end
			ST_WAITD: begin
				if (!st.div_busy)
					state_d = ST_DELTA;
			end
			ST_DELTA: begin
				cmd.op  = OP_DELTA;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.op  = OP_UPDATE;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_vld_q || m_tready) begin
					cmd.op  = OP_RESULT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_vld_q;

	`APU_AST_NEXT(a_accept_leaves_idle, s_tvalid && s_tready, state_q != ST_IDLE, "accept did not start work")
	`APU_AST_IMP(a_div_start_idle, cmd.op == OP_DIV_M || cmd.op == OP_DIV_V || cmd.op == OP_DIV_D, !st.div_busy, "divider restarted while busy")
	`APU_AST_IMP(a_no_result_overwrite, m_tvalid && !m_tready, cmd.op != OP_RESULT, "pending result overwritten")
	`APU_AST_NEXT(a_result_shows, cmd.op == OP_RESULT, m_tvalid, "result not presented")

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for adam_parameter_update. A clocked driver feeds the
// input stream from a queue, and every transfer is folded into a bit-exact
// Adam predictor. A clocked monitor compares each result with the oldest
// expected one. Config is rewritten between phases, and both sides idle
// at random.
// ----------------------------------------------------------------------------
module tb;
	import apu_pkg::*;

	localparam int DEPTH     = 1024;
	localparam int WDOG_MAX  = 20000;
	localparam int HOLD_LEN  = 2000;

	typedef struct {
		act_t        act;
		logic [9:0]  idx;
		logic [31:0] opnd;
		logic        last;
	} cmd_item_t;

	typedef struct {
		logic [9:0]  idx;
		logic [31:0] param;
		logic [15:0] step;
	} upd_result_t;

	typedef struct {
		cfg_idx_t    reg_sel;
		logic [31:0] data;
	} cfg_write_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;

	adam_parameter_update i_dut (.*);

	always #5 clk = ~clk;

	cmd_item_t   item_feed[$];
	cfg_write_t  cfg_feed[$];
	upd_result_t pending_results[$];
	cmd_item_t   cur_item;
	bit          written[DEPTH];
	int          err_cnt = 0;
	bit          hold_req = 0;

	// predictor state
	logic [31:0] lr_q, eps_q;
	logic [15:0] b1_q, b2_q, pow1_q, pow2_q, step_q;
	logic        open_q;
	logic [31:0] param_tbl[DEPTH];
	longint      m_tbl[DEPTH];
	logic [63:0] v_tbl[DEPTH];
	bit          vld_tbl[DEPTH];

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		err_cnt++;
	endtask

	function automatic logic [63:0] wide_div(input logic [127:0] num, input logic [63:0] den);
		logic [127:0] q;
		if (den == 0 || den[63] || num[127:64] >= den)
			return '1;
		q = num / den;
		return q[63:0];
	endfunction

	function automatic logic [63:0] root64(input logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'h1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void adam_update(input logic [9:0] idx, input logic [31:0] opnd);
		longint      g, m_old, m_new, p;
		logic [63:0] v_old, v_new, ga, mag, mhat, vhat, s, delta;
		logic [127:0] vsum, prod;
		g = longint'($signed(opnd));
		ga = g < 0 ? -g : g;
		m_old = vld_tbl[idx] ? m_tbl[idx] : 0;
		v_old = vld_tbl[idx] ? v_tbl[idx] : 0;
		m_new = (longint'(b1_q) * m_old + (65536 - longint'(b1_q)) * (g * 65536)) >>> 16;
		vsum = 128'(b2_q) * 128'(v_old) + (128'(65536) - 128'(b2_q)) * 128'(ga * ga);
		v_new = vsum[79:16];
		m_tbl[idx] = m_new;
		v_tbl[idx] = v_new;
		vld_tbl[idx] = 1;
		mag = m_new < 0 ? -m_new : m_new;
		mhat = wide_div(128'(mag) << 16, 64'(65536 - 32'(pow1_q)));
		vhat = wide_div(128'(v_new) << 16, 64'(65536 - 32'(pow2_q)));
		s = (root64(vhat) << 16) + 64'(eps_q);
		if (s == 0) begin
			delta = mhat != 0 ? 64'(DELTA_CAP) : 0;
		end else begin
			prod = 128'(lr_q) * 128'(mhat);
			delta = wide_div(prod >> 16, s);
		end
		if (delta > 64'(DELTA_CAP))
			delta = 64'(DELTA_CAP);
		p = longint'($signed(param_tbl[idx]));
		p = m_new < 0 ? p + longint'(delta) : p - longint'(delta);
		if (p > 64'sd2147483647)
			p = 64'sd2147483647;
		if (p < -64'sd2147483648)
			p = -64'sd2147483648;
		param_tbl[idx] = p[31:0];
	endfunction

	function automatic void fold_item(input cmd_item_t it);
		upd_result_t r;
		case (it.act)
			ACT_RESTART: begin
				foreach (vld_tbl[i])
					vld_tbl[i] = 0;
				step_q = 0;
				pow1_q = POW_RST;
				pow2_q = POW_RST;
				open_q = 0;
			end
			ACT_LOAD: begin
				param_tbl[it.idx] = it.opnd;
			end
			ACT_GRAD: begin
				if (!open_q) begin
					if (step_q != 16'hFFFF)
						step_q++;
					pow1_q = 16'((32'(pow1_q) * 32'(b1_q)) >> 16);
					pow2_q = 16'((32'(pow2_q) * 32'(b2_q)) >> 16);
					open_q = 1;
				end
				adam_update(it.idx, it.opnd);
				if (it.last)
					open_q = 0;
			end
			default: ;
		endcase
		r.idx = it.idx;
		r.param = param_tbl[it.idx];
		r.step = step_q;
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 50)
			return 0;
		if (k < 92)
			return $urandom_range(1, 3);
		return $urandom_range(20, 200);
	endfunction

	// config driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			lr_q <= LR_RST;
			b1_q <= B1_RST;
			b2_q <= B2_RST;
			eps_q <= EPS_RST;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_LR:  lr_q <= cfg_data;
					CFG_B1:  b1_q <= cfg_data[15:0];
					CFG_B2:  b2_q <= cfg_data[15:0];
					CFG_EPS: eps_q <= cfg_data;
				endcase
			end
			if (!cfg_valid || cfg_ready) begin
				if (cfg_feed.size() > 0) begin
					cfg_write_t w;
					w = cfg_feed.pop_front();
					cfg_index <= w.reg_sel;
					cfg_data <= w.data;
					cfg_valid <= 1'b1;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// input driver; new items wait until pending config writes are done
	int in_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			in_gap <= 0;
			step_q <= 0;
			pow1_q <= POW_RST;
			pow2_q <= POW_RST;
			open_q <= 0;
			foreach (vld_tbl[i])
				vld_tbl[i] <= 0;
		end else begin
			if (s_tvalid && s_tready)
				fold_item(cur_item);
			if (!s_tvalid || s_tready) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					s_tvalid <= 1'b0;
				end else if (item_feed.size() > 0 && cfg_feed.size() == 0 && !cfg_valid) begin
					cmd_item_t it;
					it = item_feed.pop_front();
					cur_item <= it;
					s_tdata <= {6'b0, it.opnd, it.idx};
					s_tuser <= it.act;
					s_tlast <= it.last;
					s_tvalid <= 1'b1;
					in_gap <= pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	int out_gap, hold_cnt;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			out_gap <= 0;
			hold_cnt <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report("unexpected transfer", m_tdata, 0);
				end else begin
					upd_result_t r;
					r = pending_results.pop_front();
					if (m_tdata[9:0] !== r.idx)
						report("result_index", m_tdata[9:0], r.idx);
					if (m_tdata[41:10] !== r.param)
						report("parameter_value", m_tdata[41:10], r.param);
					if (m_tdata[57:42] !== r.step)
						report("step_number", m_tdata[57:42], r.step);
				end
			end
			if (hold_req && hold_cnt < HOLD_LEN) begin
				hold_cnt <= hold_cnt + 1;
				m_tready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				out_gap <= pick_gap();
			end
		end
	end

	// watchdog: cycles without any transfer
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic void add_item(input act_t a, input int idx, input logic [31:0] v,
			input logic l);
		cmd_item_t it;
		it.act = a;
		it.idx = 10'(idx);
		it.opnd = v;
		it.last = l;
		if (a == ACT_LOAD)
			written[idx] = 1;
		item_feed.insert(item_feed.size(), it);
	endfunction

	function automatic void add_cfg(input logic [31:0] lr, input logic [15:0] b1,
			input logic [15:0] b2, input logic [31:0] eps);
		cfg_write_t w;
		w.reg_sel = CFG_LR;  w.data = lr;  cfg_feed.insert(cfg_feed.size(), w);
		w.reg_sel = CFG_B1;  w.data = {16'b0, b1};  cfg_feed.insert(cfg_feed.size(), w);
		w.reg_sel = CFG_B2;  w.data = {16'b0, b2};  cfg_feed.insert(cfg_feed.size(), w);
		w.reg_sel = CFG_EPS; w.data = eps; cfg_feed.insert(cfg_feed.size(), w);
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom();
			default: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
		endcase
	endfunction

	function automatic void add_random(input int n);
		int k, idx;
		for (int i = 0; i < n; i++) begin
			idx = $urandom_range(0, 9) == 0 ? $urandom_range(0, DEPTH - 1)
				: $urandom_range(0, 15);
			k = $urandom_range(0, 99);
			if (!written[idx] || k < 15) begin
				add_item(ACT_LOAD, idx, rand_operand(), 1'($urandom_range(0, 1)));
			end else if (k < 78) begin
				add_item(ACT_GRAD, idx, rand_operand(), $urandom_range(0, 3) == 0);
			end else if (k < 97) begin
				add_item(ACT_READ, idx, $urandom(), 1'($urandom_range(0, 1)));
			end else begin
				add_item(ACT_RESTART, idx, $urandom(), 1'($urandom_range(0, 1)));
			end
		end
	endfunction

	task automatic drain();
		do
			@(posedge clk);
		while (item_feed.size() > 0 || s_tvalid || pending_results.size() > 0
			|| cfg_feed.size() > 0 || cfg_valid);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, each action, restart, zero gradient
		add_item(ACT_LOAD, 0, 32'h7FFF_FFFF, 1'b0);
		add_item(ACT_LOAD, 1023, 32'h8000_0000, 1'b1);
		add_item(ACT_LOAD, 5, 32'h0, 1'b0);
		add_item(ACT_READ, 0, 32'hFFFF_FFFF, 1'b0);
		add_item(ACT_READ, 1023, 32'h0, 1'b1);
		add_item(ACT_GRAD, 0, 32'h7FFF_FFFF, 1'b0);
		add_item(ACT_GRAD, 1023, 32'h8000_0000, 1'b0);
		add_item(ACT_GRAD, 5, 32'h0, 1'b1);
		add_item(ACT_GRAD, 0, 32'hFFFF_FFFF, 1'b1);
		add_item(ACT_GRAD, 0, 32'h0001_0000, 1'b1);
		add_item(ACT_RESTART, 5, 32'h1234_5678, 1'b1);
		add_item(ACT_READ, 5, 32'h0, 1'b0);
		add_item(ACT_GRAD, 5, 32'h1, 1'b1);
		add_item(ACT_GRAD, 1023, 32'hFFFF_0000, 1'b0);
		add_item(ACT_LOAD, 0, 32'h1, 1'b1);
		add_item(ACT_GRAD, 0, 32'h8000_0000, 1'b1);
		add_item(ACT_READ, 0, 32'h0, 1'b1);
		drain();

		// zero root denominator, extreme decays
		add_cfg(32'hFFFF_FFFF, 16'h0, 16'h0, 32'h0);
		add_item(ACT_RESTART, 0, 32'h0, 1'b0);
		add_item(ACT_GRAD, 5, 32'h0, 1'b1);
		add_item(ACT_GRAD, 0, 32'h0000_8000, 1'b1);
		add_random(180);
		drain();

		add_cfg(32'h0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		add_random(170);
		drain();

		add_cfg(LR_RST, B1_RST, B2_RST, EPS_RST);
		hold_req = 1;
		add_random(200);
		drain();

		add_cfg($urandom(), 16'($urandom()), 16'($urandom()), $urandom_range(0, 1 << 16));
		add_random(170);
		drain();

		repeat (300) @(posedge clk);
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
